// ----- design/pbm_pkg.sv -----
// Shared types, constants and helpers of the IPv4 prefix blocklist match unit.
package pbm_pkg;

	localparam int MAX_ENTRIES_DEF = 64;
	localparam int ADDR_W          = 32;
	localparam int PLEN_W          = 6;
	localparam int OP_W            = 2;
	localparam int ENTRY_W         = ADDR_W + PLEN_W;

	localparam logic [PLEN_W-1:0] PLEN_MAX = PLEN_W'(ADDR_W);

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR  = 2'd0,
		OP_ADD    = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_NONE   = 2'd3
	} pbm_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_HOLD
	} pbm_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic scan;
		logic finish;
	} pbm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
		logic is_lookup;
		logic scan_done;
	} pbm_sts_t;

	// Network mask for a prefix length already clipped to at most 32.
	function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
		logic [ADDR_W-1:0] mask;
		if (plen == '0) begin
			mask = '0;
		end else begin
			mask = {ADDR_W{1'b1}} << (PLEN_MAX - plen);
		end
		return mask;
	endfunction

endpackage

// ----- design/pbm_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module pbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- design/pbm_datapath.sv -----
// Datapath: entry table, entry count, lookup scan and output register.
module pbm_datapath
	import pbm_pkg::*;
#(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	localparam int CNT_W      = $clog2(MAX_ENTRIES + 1),
	localparam int IDX_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pbm_cmd_t          cmd,
	output pbm_sts_t          sts,
	input  logic [OP_W-1:0]   operation,
	input  logic [ADDR_W-1:0] addr,
	input  logic [PLEN_W-1:0] prefix_len,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              blocked,
	output logic              accepted
);

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   idx_q;
	logic               rd_valid_q;
	logic               hit_q;
	logic [ADDR_W-1:0]  addr_q;
	logic               out_valid_q;
	logic               blocked_q;
	logic               accepted_q;

	logic               full;
	logic               is_add;
	logic               is_clear;
	logic               wr_en;
	logic               rd_en;
	logic [PLEN_W-1:0]  plen_clip;
	logic [ENTRY_W-1:0] rd_data;
	logic [ADDR_W-1:0]  rd_addr;
	logic [PLEN_W-1:0]  rd_plen;
	logic               match;

	assign full      = (count_q >= CNT_MAX);
	assign is_add    = (operation == OP_ADD);
	assign is_clear  = (operation == OP_CLEAR);
	assign wr_en     = cmd.accept && is_add && !full;
	assign plen_clip = (prefix_len > PLEN_MAX) ? PLEN_MAX : prefix_len;
	assign rd_en     = cmd.scan && (idx_q < count_q);

	assign rd_addr = rd_data[ENTRY_W-1:PLEN_W];
	assign rd_plen = rd_data[PLEN_W-1:0];
	assign match   = rd_valid_q && (((addr_q ^ rd_addr) & prefix_mask(rd_plen)) == '0);

	assign sts.out_free  = !out_valid_q || !out_stall;
	assign sts.is_lookup = (operation == OP_LOOKUP);
	assign sts.scan_done = match || (!rd_valid_q && (idx_q == count_q));

	pbm_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[IDX_W-1:0]),
		.wdata ({addr, plen_clip}),
		.re    (rd_en),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			rd_valid_q  <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept && is_clear) begin
				count_q <= '0;
			end else if (wr_en) begin
				count_q <= count_q + 1'b1;
			end

			if (cmd.accept) begin
				idx_q      <= '0;
				rd_valid_q <= 1'b0;
				hit_q      <= 1'b0;
			end else if (cmd.scan) begin
				if (rd_en) begin
					idx_q <= idx_q + 1'b1;
				end
				rd_valid_q <= rd_en;
				if (match) begin
					hit_q <= 1'b1;
				end
			end

			if ((cmd.accept && !sts.is_lookup) || cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_q <= addr;
		end
		if (cmd.accept && !sts.is_lookup) begin
			blocked_q  <= 1'b0;
			accepted_q <= wr_en;
		end else if (cmd.finish) begin
			blocked_q  <= hit_q;
			accepted_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign blocked   = blocked_q;
	assign accepted  = accepted_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("entry count above table depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == '0) || (count_q == $past(count_q) + 1'b1))
		else $error("entry count moved by more than one");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && is_add && full) |=> out_valid_q && !accepted_q && !blocked_q)
		else $error("add on a full table was not dropped");

	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(blocked_q && accepted_q))
		else $error("result flags both set");

endmodule

// ----- design/pbm_ctrl.sv -----
// Controller: sequences request intake, the lookup scan and result delivery.
module pbm_ctrl
	import pbm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  pbm_sts_t sts,
	output pbm_cmd_t cmd
);

	pbm_state_t state_q;
	pbm_state_t state_d;
	logic       accept;

	assign in_stall = (state_q != ST_IDLE) || !sts.out_free;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && sts.is_lookup) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.scan_done) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: cmd.accept = accept;
			ST_SCAN: cmd.scan   = 1'b1;
			ST_HOLD: cmd.finish = sts.out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_scan_after_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && sts.is_lookup) |=> (state_q == ST_SCAN))
		else $error("lookup did not start a scan");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !cmd.accept)
		else $error("request taken while busy");

	a_finish_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (state_q == ST_IDLE))
		else $error("lookup result delivered without returning to idle");

endmodule

// ----- design/ipv4_prefix_blocklist_match_unit.sv -----
// Top level of the IPv4 prefix blocklist match unit.
// Each request is a clear, an add, a lookup or a no-op (OP_NONE), and each gives exactly
// one result. Clear and add finish in the cycle they are taken, so one can be taken every
// cycle while the result register drains. A lookup walks the stored entries through the
// table's single read port, one entry per cycle, and stops at the first hit. No new request
// is taken while a lookup scans, nor while its finished result waits on out_stall. The table
// holds MAX_ENTRIES entries; an add to a full table is dropped with accepted low, and a
// prefix length above 32 is stored as 32.
module ipv4_prefix_blocklist_match_unit
	import pbm_pkg::*;
#(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [OP_W-1:0]   operation,
	input  logic [ADDR_W-1:0] addr,
	input  logic [PLEN_W-1:0] prefix_len,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              blocked,
	output logic              accepted
);

	pbm_cmd_t cmd;
	pbm_sts_t sts;

	pbm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	pbm_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.operation  (operation),
		.addr       (addr),
		.prefix_len (prefix_len),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.blocked    (blocked),
		.accepted   (accepted)
	);

endmodule
